// ===== hw/rtl/rsft_pkg.sv =====
// Shared types and constants of the rack switch forwarding table.
package rsft_pkg;

   localparam int MAX_UPLINKS = 8;    // uplinks the port mask can name
   localparam int KEY_W  = 18;   // {addr_type, addr_a, addr_b}
   localparam int HOP_W  = 8;    // width of hop_mask and port_mask
   localparam int ADDR_W = 8;
   localparam int TYPE_W = 2;
   localparam int UCNT_W = 4;    // width of up_count

   localparam logic [1:0] OP_LOOKUP    = 2'd0;
   localparam logic [1:0] OP_NEIGHBOUR = 2'd1;
   localparam logic [1:0] OP_DEST      = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_REJECT   = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_SELF_IGN = 2'd3;

   localparam logic [1:0] CSR_SELF_TYPE = 2'd0;
   localparam logic [1:0] CSR_SELF_A    = 2'd1;
   localparam logic [1:0] CSR_SELF_B    = 2'd2;
   localparam logic [1:0] CSR_UP_COUNT  = 2'd3;

   // Search token that walks the row of entry cells, one cell per cycle.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             hit;        // some earlier cell holds the key
      logic             hit_reach;
      logic [HOP_W-1:0] hit_hops;
      logic             free_seen;  // some earlier cell is empty
   } token_type;

   // Update broadcast to all cells at the end of a transaction.
   typedef struct packed {
      logic             install;    // write the marked cell
      logic             use_hit;    // marked cell: hit cell, else first free cell
      logic             remove;     // invalidate the hit cell
      logic             drop;       // clear drop_mask in every valid entry
      logic [HOP_W-1:0] drop_mask;
      logic [KEY_W-1:0] key;
      logic             reach;
      logic [HOP_W-1:0] hops;
   } cmd_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [TYPE_W-1:0] addr_type;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              link_present;
      logic [HOP_W-1:0]  hop_mask;
   } req_type;

endpackage

// ===== hw/rtl/rsft_cell.sv =====
// One entry cell of the forwarding table row.
module rsft_cell (
   input  logic                clock,
   input  logic                reset,
   input  rsft_pkg::token_type tok_i,
   output rsft_pkg::token_type tok_o,
   input  rsft_pkg::cmd_type   cmd_i
);
   import rsft_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff;
   logic             reach_ff;
   logic [HOP_W-1:0] hops_ff;
   logic             hit_mark_ff, hit_mark_in;
   logic             free_mark_ff, free_mark_in;
   token_type        tok_ff, tok_in;
   logic             match;
   logic             claim_hit;
   logic             claim_free;
   logic             write_here;

   always_comb begin
      match      = tok_i.valid && valid_ff && (key_ff == tok_i.key);
      claim_hit  = match && !tok_i.hit;
      claim_free = tok_i.valid && !valid_ff && !tok_i.free_seen;

      tok_in = tok_i;
      if (claim_hit) begin
         tok_in.hit       = 1'b1;
         tok_in.hit_reach = reach_ff;
         tok_in.hit_hops  = hops_ff;
      end
      if (claim_free) begin
         tok_in.free_seen = 1'b1;
      end

      hit_mark_in  = tok_i.valid ? claim_hit  : hit_mark_ff;
      free_mark_in = tok_i.valid ? claim_free : free_mark_ff;

      write_here = cmd_i.install && (cmd_i.use_hit ? hit_mark_ff : free_mark_ff);
      valid_in   = valid_ff;
      if (write_here) begin
         valid_in = 1'b1;
      end else if (cmd_i.remove && hit_mark_ff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         hit_mark_ff  <= 1'b0;
         free_mark_ff <= 1'b0;
         tok_ff       <= '0;
      end else begin
         valid_ff     <= valid_in;
         hit_mark_ff  <= hit_mark_in;
         free_mark_ff <= free_mark_in;
         tok_ff       <= tok_in;
      end
   end

   // Entry payload is only read while the entry is valid.
   always_ff @(posedge clock) begin
      if (write_here) begin
         key_ff   <= cmd_i.key;
         reach_ff <= cmd_i.reach;
         hops_ff  <= cmd_i.hops;
      end else if (cmd_i.drop && valid_ff) begin
         hops_ff  <= hops_ff & ~cmd_i.drop_mask;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== hw/rtl/rack_switch_forwarding_table_core.sv =====
// Top level of the rack switch forwarding table: control, routing decision and cell row.
//
//   Channel  | Direction | Handshake             | Contents
//   ---------+-----------+-----------------------+-------------------------------------------
//   req_     | in        | req_tvalid/req_tready | opcode, address, link flag, hop mask
//   rsp_     | out       | rsp_tvalid/rsp_tready | port_mask, status
//   csr_     | in        | csr_wr_en             | self address and uplink count registers
//
// Lookups and set-destination transactions walk a search token through the
// row of TABLE_ENTRIES cells, one cell per cycle, before they finish;
// set-neighbour and unknown opcodes go straight to the finishing state. A
// link drop clears its bit in every valid entry in the update that ends the
// transaction.
// Reset is synchronous and empties the table, drops all links and clears
// the registers; no clearing pass is needed. A stalled result stays in the
// output register while the next request is already accepted and searched.
module rack_switch_forwarding_table_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request transaction kind, fields from bit 0 up: opcode[1:0].
   input  logic [1:0]  req_tuser,
   // Request transaction, fields from bit 0 up: addr_type[1:0], addr_a[9:2],
   // addr_b[17:10], link_present[18], hop_mask[26:19], zero pad.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Response transaction, fields from bit 0 up: port_mask[7:0], status[9:8],
   // zero pad.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Register write port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import rsft_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]             state_ff, state_in;
   req_type                req_ff, req_c;
   token_type              head_ff, head_in;
   token_type              tail_ff;
   token_type              chain [TABLE_ENTRIES+1];
   cmd_type                cmd_raw, cmd_c;

   logic [TYPE_W-1:0]      self_type_ff;
   logic [ADDR_W-1:0]      self_a_ff, self_b_ff;
   logic [UCNT_W-1:0]      up_count_ff;
   logic [MAX_UPLINKS-1:0] link_up_ff, link_up_in, link_next;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HOP_W-1:0]       rsp_mask_ff;
   logic [1:0]             rsp_status_ff;

   logic                   req_accept;
   logic                   scan_op;
   logic                   out_free;
   logic                   apply;
   logic [UCNT_W-1:0]      u_eff;
   logic [MAX_UPLINKS-1:0] umask, live, sel_vec, nb_sel;
   logic [MAX_UPLINKS+HOP_W-1:0] live_wide, umask_wide, sel_wide;
   logic [HOP_W-1:0]       live8, umask8, sel8, hop_sel, drop_mask;
   logic [ADDR_W-1:0]      sel;
   logic                   have_sel;
   logic                   is_self;
   logic                   nb_reject, nb_cur;
   logic [UCNT_W-1:0]      hop_cnt;
   logic                   remove;
   logic [HOP_W-1:0]       mask_c;
   logic [1:0]             status_c;

   // Field unpacking of the request bus.
   assign req_c.opcode       = req_tuser;
   assign req_c.addr_type    = req_tdata[1:0];
   assign req_c.addr_a       = req_tdata[9:2];
   assign req_c.addr_b       = req_tdata[17:10];
   assign req_c.link_present = req_tdata[18];
   assign req_c.hop_mask     = req_tdata[26:19];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign scan_op    = (req_c.opcode == OP_LOOKUP) || (req_c.opcode == OP_DEST);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign apply      = (state_ff == ST_FINISH) && out_free;

   // The search token enters cell 0 the cycle after the request is taken.
   always_comb begin
      head_in       = '0;
      head_in.valid = req_accept && scan_op;
      head_in.key   = {req_c.addr_type, req_c.addr_a, req_c.addr_b};
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      rsft_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (chain[g]),
         .tok_o (chain[g+1]),
         .cmd_i (cmd_c)
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = scan_op ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (chain[TABLE_ENTRIES].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Live uplinks are the raised links below the effective uplink count.
   always_comb begin
      u_eff = ({28'd0, up_count_ff} > MAX_UPLINKS) ? UCNT_W'(MAX_UPLINKS) : up_count_ff;
      for (int i = 0; i < MAX_UPLINKS; i++) begin
         umask[i]   = (i < int'(u_eff));
         sel_vec[i] = (sel == ADDR_W'(i));
         nb_sel[i]  = (req_ff.addr_b == ADDR_W'(i));
      end
      live       = link_up_ff & umask;
      live_wide  = {{HOP_W{1'b0}}, live};
      umask_wide = {{HOP_W{1'b0}}, umask};
      sel_wide   = {{HOP_W{1'b0}}, sel_vec & live};
      live8      = live_wide[HOP_W-1:0];
      umask8     = umask_wide[HOP_W-1:0];
      sel8       = sel_wide[HOP_W-1:0];
   end

   // Address field that names the preferred uplink for this address type.
   always_comb begin
      have_sel = 1'b1;
      sel      = req_ff.addr_b;
      if (req_ff.addr_type == 2'd2) begin
         sel = req_ff.addr_a;
      end else if (req_ff.addr_type == 2'd0) begin
         have_sel = 1'b0;
      end
      for (int i = 0; i < HOP_W; i++) begin
         hop_sel[i]   = req_ff.hop_mask[i] && (sel == ADDR_W'(i));
         drop_mask[i] = (req_ff.addr_b == ADDR_W'(i));
      end
      hop_cnt = UCNT_W'($countones(req_ff.hop_mask));
      is_self = (req_ff.addr_type == self_type_ff) && (req_ff.addr_a == self_a_ff) &&
                (req_ff.addr_b == self_b_ff);
      nb_reject = (req_ff.addr_type != 2'd1) || (req_ff.addr_a != self_a_ff) ||
                  (req_ff.addr_b >= ADDR_W'(u_eff));
      nb_cur    = |(link_up_ff & nb_sel);
      // A mask equal to the default route needs no entry.
      remove = (req_ff.hop_mask != '0) &&
               (have_sel ? ((hop_cnt == UCNT_W'(1)) && (|hop_sel)) : (hop_cnt == u_eff));
   end

   // Decision made in the finishing cycle from the request and search result.
   always_comb begin
      mask_c    = '0;
      status_c  = STAT_OK;
      cmd_raw   = '0;
      cmd_raw.key       = {req_ff.addr_type, req_ff.addr_a, req_ff.addr_b};
      cmd_raw.reach     = (req_ff.hop_mask != '0);
      cmd_raw.hops      = req_ff.hop_mask & umask8;
      cmd_raw.drop_mask = drop_mask;
      link_next = link_up_ff;
      case (req_ff.opcode)
         OP_LOOKUP: begin
            if (!is_self) begin
               if (tail_ff.hit) begin
                  mask_c = tail_ff.hit_reach ? (tail_ff.hit_hops & live8) : '0;
               end else if (have_sel && (|(sel_vec & live))) begin
                  mask_c = sel8;
               end else begin
                  mask_c = live8;
               end
            end
         end
         OP_NEIGHBOUR: begin
            if (nb_reject) begin
               status_c = STAT_REJECT;
            end else if (nb_cur != req_ff.link_present) begin
               if (req_ff.link_present) begin
                  link_next = link_up_ff | nb_sel;
               end else begin
                  link_next    = link_up_ff & ~nb_sel;
                  cmd_raw.drop = 1'b1;
               end
            end
         end
         OP_DEST: begin
            if (is_self) begin
               status_c = STAT_SELF_IGN;
            end else if (remove) begin
               cmd_raw.remove = 1'b1;
            end else if (tail_ff.hit) begin
               cmd_raw.install = 1'b1;
               cmd_raw.use_hit = 1'b1;
            end else if (tail_ff.free_seen) begin
               cmd_raw.install = 1'b1;
            end else begin
               status_c = STAT_FULL;
            end
         end
         default: begin
         end
      endcase
      cmd_c = cmd_raw;
      if (!apply) begin
         cmd_c.install = 1'b0;
         cmd_c.remove  = 1'b0;
         cmd_c.drop    = 1'b0;
      end
      link_up_in = apply ? link_next : link_up_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         link_up_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         self_type_ff <= '0;
         self_a_ff    <= '0;
         self_b_ff    <= '0;
         up_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         link_up_ff   <= link_up_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SELF_TYPE: self_type_ff <= csr_wdata[TYPE_W-1:0];
               CSR_SELF_A:    self_a_ff    <= csr_wdata;
               CSR_SELF_B:    self_b_ff    <= csr_wdata;
               CSR_UP_COUNT:  up_count_ff  <= csr_wdata[UCNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_c;
      end
      if ((state_ff == ST_SCAN) && chain[TABLE_ENTRIES].valid) begin
         tail_ff <= chain[TABLE_ENTRIES];
      end
      if (apply) begin
         rsp_mask_ff   <= mask_c;
         rsp_status_ff <= status_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_mask_ff};

endmodule

// ===== hw/rtl/rsft_checker.sv =====
// Port-level checks of the forwarding table core and their binding.
module rsft_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import rsft_pkg::*;

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // One transaction at a time: the request side closes once a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Only a successful transaction can carry a nonzero port mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:8] != STAT_OK) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("port mask on a failed transaction");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rack_switch_forwarding_table_core rsft_checker u_rsft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
